// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the double-ended queue, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

// ----- rtl/dq_pkg.sv -----
// Package with the types and constants of the double-ended queue.
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CMD_W         = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int LENGTH_W      = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] length;
        logic                front_valid;
        logic [VALUE_W-1:0]  front_value;
        logic                back_valid;
        logic [VALUE_W-1:0]  back_value;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/dq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = dq_pkg::VALUE_W,
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// Top level of the double-ended queue: ring buffer in RAM with cached end values.
// Result: a push, a query or a pop that leaves the queue empty answers in the cycle after
//   the request transaction; a pop that leaves entries answers after the fill state.
// Rate: one transaction per cycle for pushes and queries while the receiver does not stall;
//   such pops stall new requests in the fill state, which reads the new end from the RAM.
// Reset: asynchronous, active low; the queue is empty at once and the RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_stall,
    input  wire dq_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output dq_pkg::rsp_t      rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // The front and back values live in registers next to the ring indices, so a push
    // or a query answers without touching the RAM. A pop that leaves entries behind must
    // fetch the new end from the RAM, which costs the extra fill state.

    dq_pkg::state_t state_reg, state_next;

    logic [AW-1:0] front_idx_reg, front_idx_next;
    logic [AW-1:0] back_idx_reg, back_idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [dq_pkg::VALUE_W-1:0] front_val_reg, front_val_next;
    logic [dq_pkg::VALUE_W-1:0] back_val_reg, back_val_next;
    logic                       fill_front_reg, fill_front_next;
    dq_pkg::rsp_t               rsp_reg, rsp_next;

    logic                       req_acc;
    logic                       need_fill;
    logic                       load_rsp;
    logic                       is_pop;
    logic [dq_pkg::STATUS_W-1:0] status;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [dq_pkg::VALUE_W-1:0] rd_data;

    logic          is_empty;
    logic          is_full;
    logic [AW-1:0] front_prev;
    logic [AW-1:0] front_succ;
    logic [AW-1:0] back_prev;
    logic [AW-1:0] back_prev2;
    logic [AW-1:0] back_succ;

    // Ring index arithmetic; DEPTH need not be a power of two.
    assign front_prev = (front_idx_reg == '0) ? LAST_IDX : front_idx_reg - AW'(1);
    assign front_succ = (front_idx_reg == LAST_IDX) ? '0 : front_idx_reg + AW'(1);
    assign back_prev  = (back_idx_reg == '0) ? LAST_IDX : back_idx_reg - AW'(1);
    assign back_prev2 = (back_prev == '0) ? LAST_IDX : back_prev - AW'(1);
    assign back_succ  = (back_idx_reg == LAST_IDX) ? '0 : back_idx_reg + AW'(1);

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_CNT);

    // A new transaction is taken only in idle, and only when the result register will be
    // free after this edge.
    assign req_stall = (state_reg != dq_pkg::ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign req_acc   = req_valid && !req_stall;
    assign is_pop    = (req.cmd == dq_pkg::CMD_POP_FRONT) || (req.cmd == dq_pkg::CMD_POP_BACK);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (req_acc && need_fill)
                begin
                    state_next = dq_pkg::ST_FILL;
                end
            end
            dq_pkg::ST_FILL:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        front_idx_next  = front_idx_reg;
        back_idx_next   = back_idx_reg;
        count_next      = count_reg;
        front_val_next  = front_val_reg;
        back_val_next   = back_val_reg;
        fill_front_next = fill_front_reg;
        need_fill       = 1'b0;
        load_rsp        = 1'b0;
        status          = dq_pkg::STATUS_DONE;
        wr_en           = 1'b0;
        wr_addr         = back_idx_reg;
        rd_en           = 1'b0;
        rd_addr         = front_succ;

        case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.cmd)
                        dq_pkg::CMD_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = front_prev;
                                front_idx_next = front_prev;
                                count_next     = count_reg + CW'(1);
                                front_val_next = req.value;
                                if (is_empty)
                                begin
                                    back_val_next = req.value;
                                end
                            end
                        end
                        dq_pkg::CMD_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status = dq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = back_idx_reg;
                                back_idx_next = back_succ;
                                count_next    = count_reg + CW'(1);
                                back_val_next = req.value;
                                if (is_empty)
                                begin
                                    front_val_next = req.value;
                                end
                            end
                        end
                        dq_pkg::CMD_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                front_idx_next  = front_succ;
                                count_next      = count_reg - CW'(1);
                                rd_addr         = front_succ;
                                fill_front_next = 1'b1;
                                need_fill       = (count_reg != CW'(1));
                                rd_en           = need_fill;
                            end
                        end
                        dq_pkg::CMD_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status = dq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                back_idx_next   = back_prev;
                                count_next      = count_reg - CW'(1);
                                rd_addr         = back_prev2;
                                fill_front_next = 1'b0;
                                need_fill       = (count_reg != CW'(1));
                                rd_en           = need_fill;
                            end
                        end
                        default:
                        begin
                            // Query, and the unused codes, leave the queue alone.
                            status = dq_pkg::STATUS_DONE;
                        end
                    endcase
                    load_rsp = !need_fill;
                end
            end
            dq_pkg::ST_FILL:
            begin
                // The RAM word read for the pop arrives now and becomes the new end.
                if (fill_front_reg)
                begin
                    front_val_next = rd_data;
                end
                else
                begin
                    back_val_next = rd_data;
                end
                load_rsp = 1'b1;
            end
            default:
            begin
                load_rsp = 1'b0;
            end
        endcase

        rsp_next.status      = status;
        rsp_next.length      = dq_pkg::LENGTH_W'(count_next);
        rsp_next.front_valid = (count_next != '0);
        rsp_next.front_value = (count_next != '0) ? front_val_next : '0;
        rsp_next.back_valid  = (count_next != '0);
        rsp_next.back_value  = (count_next != '0) ? back_val_next : '0;

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && rsp_stall)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::ST_IDLE;
            front_idx_reg <= '0;
            back_idx_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            back_idx_reg  <= back_idx_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg  <= front_val_next;
        back_val_reg   <= back_val_next;
        fill_front_reg <= fill_front_next;
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    dq_ram #(
        .WIDTH (dq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The back index must always sit count entries past the front index, modulo DEPTH.
    logic [AW+1:0] idx_sum;
    logic [AW+1:0] idx_wrap;

    assign idx_sum  = (AW+2)'(front_idx_reg) + (AW+2)'(count_reg);
    assign idx_wrap = (idx_sum >= (AW+2)'(DEPTH)) ? idx_sum - (AW+2)'(DEPTH) : idx_sum;

    `DQ_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    `DQ_ASSERT_IMPLIES(a_ring_consistent, 1'b1, idx_wrap[AW-1:0] == back_idx_reg)
    `DQ_ASSERT_IMPLIES(a_fill_out_free, state_reg == dq_pkg::ST_FILL, !rsp_valid_reg)
    `DQ_ASSERT_NEXT(a_pop_fills, req_acc && is_pop && (count_reg > CW'(1)),
        state_reg == dq_pkg::ST_FILL)

endmodule

`default_nettype wire

// ----- sim/double_ended_queue_tb.sv -----
// Self-checking testbench for the double-ended queue: directed and random commands, scoreboard.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    import dq_pkg::*;

    // The ring in the predictor has the same depth as the block under test.
    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

    // Command codes above the query code have no function of their own and act as a query.
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_QUERY + 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;

    localparam int RANDOM_ITEMS = 1330;
    localparam int QUIET_ITEMS  = 150;   // final transactions sent and taken with no idling
    localparam int HOLD_AT      = 400;   // request count at which the long receiver hold starts
    localparam int HOLD_CYCLES  = 250;
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction before giving up
    localparam int DRAIN_CYCLES = 20;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // Requests waiting to be driven, and responses predicted but not yet seen.
    req_t request_backlog[$];
    rsp_t expected_rsp[$];

    // Predictor state: a ring of slots with a front slot, a slot one past the back, and a count.
    logic [VALUE_W-1:0]  ring_slot[QUEUE_DEPTH];
    logic [SLOT_W-1:0]   front_slot = '0;
    logic [SLOT_W-1:0]   past_back_slot = '0;
    logic [LENGTH_W-1:0] fill_count = '0;

    int   accepted_count = 0;
    int   quiet_from     = 32'h7fff_ffff;
    int   total_requests = 0;
    int   mismatch_count = 0;
    int   idle_cycles    = 0;
    logic req_taken      = 1'b0;

    int   send_pause = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;

    double_ended_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // Applies one request transaction to the predictor and returns the response it must produce.
    // A push writes a slot before any read of it, so slots never written are never looked at.
    function automatic rsp_t apply_request(req_t r);
        rsp_t                o;
        logic [SLOT_W-1:0]   back_slot;
        o = '0;
        o.status = STATUS_DONE;
        case (r.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (fill_count == QUEUE_DEPTH)
                begin
                    o.status = STATUS_FULL;
                end
                else if (r.cmd == CMD_PUSH_FRONT)
                begin
                    front_slot = front_slot - SLOT_W'(1);
                    ring_slot[front_slot] = r.value;
                    fill_count = fill_count + LENGTH_W'(1);
                end
                else
                begin
                    ring_slot[past_back_slot] = r.value;
                    past_back_slot = past_back_slot + SLOT_W'(1);
                    fill_count = fill_count + LENGTH_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (fill_count == 0)
                begin
                    o.status = STATUS_EMPTY;
                end
                else if (r.cmd == CMD_POP_FRONT)
                begin
                    front_slot = front_slot + SLOT_W'(1);
                    fill_count = fill_count - LENGTH_W'(1);
                end
                else
                begin
                    past_back_slot = past_back_slot - SLOT_W'(1);
                    fill_count = fill_count - LENGTH_W'(1);
                end
            end
            default:
            begin
                // Query and the unused codes leave the queue as it is.
            end
        endcase
        o.length = fill_count;
        if (fill_count != 0)
        begin
            back_slot = past_back_slot - SLOT_W'(1);
            o.front_valid = 1'b1;
            o.front_value = ring_slot[front_slot];
            o.back_valid  = 1'b1;
            o.back_value  = ring_slot[back_slot];
        end
        return o;
    endfunction

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        mismatch_count++;
        $display("[%0t] %s: got %0h, expected %0h", $time, what, seen, wanted);
    endtask

    task automatic compare_response(input rsp_t got, input rsp_t want);
        if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.length !== want.length)
            report_mismatch("length", 64'(got.length), 64'(want.length));
        if (got.front_valid !== want.front_valid)
            report_mismatch("front_valid", 64'(got.front_valid), 64'(want.front_valid));
        if (got.front_value !== want.front_value)
            report_mismatch("front_value", 64'(got.front_value), 64'(want.front_value));
        if (got.back_valid !== want.back_valid)
            report_mismatch("back_valid", 64'(got.back_valid), 64'(want.back_valid));
        if (got.back_value !== want.back_value)
            report_mismatch("back_value", 64'(got.back_value), 64'(want.back_value));
    endtask

    // Request driver. A new request is presented only once the previous one has been taken,
    // so a stalled payload never moves. Random pauses follow some transactions until the quiet
    // stretch at the end of the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (send_pause > 0)
                begin
                    req_valid  <= 1'b0;
                    send_pause <= send_pause - 1;
                end
                else if (request_backlog.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req       <= request_backlog.pop_front();
                    if (accepted_count < quiet_from && $urandom_range(0, 9) == 0)
                        send_pause <= $urandom_range(1, 6);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response receiver. Once in the run it holds off for a long stretch while requests keep
    // coming, which backs the block up until it stalls its request side. Otherwise it stalls
    // in random bursts, and not at all in the quiet stretch.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && accepted_count >= HOLD_AT)
            begin
                rsp_stall <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (accepted_count < quiet_from && $urandom_range(0, 7) == 0)
            begin
                rsp_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 5);
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Monitor. Every request transaction feeds the predictor; every response transaction is
    // checked against the oldest prediction. The watchdog counts cycles with work outstanding
    // and no transaction on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(apply_request(req));
                accepted_count <= accepted_count + 1;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("response with nothing expected", 64'(rsp.length), 64'(0));
                else
                    compare_response(rsp, expected_rsp.pop_front());
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (!req_valid && request_backlog.size() == 0 && expected_rsp.size() == 0))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [CMD_W-1:0]   c;
        logic [VALUE_W-1:0] v;
        int                 level;
        int                 mode;
        int                 span;
        int                 push_weight;
        int                 roll;

        // Directed part: pops and queries on an empty queue, the unused codes, extreme values
        // at both ends, draining from both sides, and a queue that becomes empty again.
        request_backlog.push_back('{CMD_POP_FRONT, 32'hFFFF_FFFF});
        request_backlog.push_back('{CMD_POP_BACK, 32'h0000_0000});
        request_backlog.push_back('{CMD_QUERY, 32'h1234_5678});
        request_backlog.push_back('{CMD_UNUSED_FIRST, 32'hDEAD_BEEF});
        request_backlog.push_back('{CMD_UNUSED_FIRST + 3'd1, 32'h0000_0001});
        request_backlog.push_back('{CMD_UNUSED_LAST, 32'h8000_0000});
        request_backlog.push_back('{CMD_PUSH_FRONT, 32'h0000_0000});
        request_backlog.push_back('{CMD_PUSH_BACK, 32'hFFFF_FFFF});
        request_backlog.push_back('{CMD_PUSH_FRONT, 32'hA5A5_A5A5});
        request_backlog.push_back('{CMD_PUSH_BACK, 32'h5A5A_5A5A});
        request_backlog.push_back('{CMD_QUERY, 32'h0000_0000});
        request_backlog.push_back('{CMD_POP_FRONT, 32'h0000_0000});
        request_backlog.push_back('{CMD_POP_BACK, 32'h0000_0000});
        request_backlog.push_back('{CMD_POP_FRONT, 32'h0000_0000});
        request_backlog.push_back('{CMD_POP_BACK, 32'h0000_0000});
        request_backlog.push_back('{CMD_POP_BACK, 32'h0000_0000});
        request_backlog.push_back('{CMD_PUSH_BACK, 32'h8000_0001});
        request_backlog.push_back('{CMD_POP_FRONT, 32'h0000_0000});
        request_backlog.push_back('{CMD_PUSH_FRONT, 32'h7FFF_FFFE});
        request_backlog.push_back('{CMD_POP_BACK, 32'hFFFF_FFFF});
        request_backlog.push_back('{CMD_PUSH_BACK, 32'hC3C3_C3C3});

        // Random part in episodes: filling runs drive the queue to full and push against it,
        // draining runs empty it and pop against it, mixed runs wander in between. A small
        // share of queries and unused codes is mixed in throughout.
        level = 1;
        while (request_backlog.size() < RANDOM_ITEMS + 21)
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 96);
            push_weight = (mode == 0) ? 13 : (mode == 1) ? 2 : 7;
            repeat (span)
            begin
                roll = $urandom_range(0, 15);
                case ($urandom_range(0, 7))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = $urandom;
                endcase
                if (roll == 0)
                    c = CMD_W'($urandom_range(CMD_QUERY, CMD_UNUSED_LAST));
                else if (roll <= push_weight)
                    c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                if ((c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) && level < QUEUE_DEPTH)
                    level++;
                else if ((c == CMD_POP_FRONT || c == CMD_POP_BACK) && level > 0)
                    level--;
                request_backlog.push_back('{c, v});
            end
        end
        total_requests = request_backlog.size();
        quiet_from     = total_requests - QUIET_ITEMS;

        // Reset is held low from the start and released on a falling edge, away from the rising edge.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_requests)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dq_pkg.sv
rtl/dq_ram.sv
rtl/double_ended_queue.sv
sim/double_ended_queue_tb.sv
